// File: rtl/knps_pkg.sv
package knps_pkg;

	localparam int NUM_POINTS_DEF    = 256;
	localparam int MAX_NEIGHBORS_DEF = 16;

	localparam int COORD_W   = 20;
	localparam int ABS_W     = COORD_W + 1;
	localparam int SQ_W      = 2 * COORD_W + 1;
	localparam int DIST_W    = 42;
	localparam int SLOT_W    = 8;
	localparam int IDX_OUT_W = 9;
	localparam int RANK_W    = 4;
	localparam int CFG_W     = 5;
	localparam int TABLE_MAX = 1 << SLOT_W;

	localparam logic [CFG_W-1:0]     NEIGHBORS_RESET = 5'd4;
	localparam logic [IDX_OUT_W-1:0] NO_INDEX        = 9'h1FF;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic write;
		logic start;
		logic scan;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic scan_end;
		logic pipe_busy;
		logic out_free;
		logic emit_last;
	} status_t;

endpackage

// File: rtl/k_nearest_point_select_top.sv
// Write transaction: accepted only while idle, no result.
// Query transaction: accept, then a scan of min(NUM_POINTS,256) table slots (one table
// read per cycle), pipeline drain, then k results, each loaded when the output is free.
// Input is not accepted again until the last result is loaded into the output register.
// Reset clears all alive flags, empties the nearest list and sets neighbors_wanted to 4.
module k_nearest_point_select_top
	import knps_pkg::*;
#(
	parameter int NUM_POINTS    = NUM_POINTS_DEF,
	parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [71:0]       s_tdata,  // slot, pos_x, pos_y, pos_z, live, zero pad
	input  logic              s_tuser,  // op
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [55:0]       m_tdata,  // rank, point_index, dist_sq, zero pad
	output logic              m_tlast,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int TABLE_DEPTH = (NUM_POINTS < TABLE_MAX) ? NUM_POINTS : TABLE_MAX;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	cmd_t    cmd;
	status_t status;

	logic               cand_valid;
	logic [DIST_W-1:0]  cand_dist;
	logic [IDX_W-1:0]   cand_idx;
	logic [RANK_W-1:0]    out_rank;
	logic [IDX_OUT_W-1:0] out_index;
	logic [DIST_W-1:0]    out_dist;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {1'b0, out_dist, out_index, out_rank};

	knps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.op       (s_tuser),
		.status   (status),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	knps_dist #(
		.NUM_POINTS (NUM_POINTS)
	) u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.slot       (s_tdata[7:0]),
		.pos_x      (s_tdata[27:8]),
		.pos_y      (s_tdata[47:28]),
		.pos_z      (s_tdata[67:48]),
		.live       (s_tdata[68]),
		.cand_valid (cand_valid),
		.cand_dist  (cand_dist),
		.cand_idx   (cand_idx),
		.scan_end   (status.scan_end),
		.pipe_busy  (status.pipe_busy)
	);

	knps_best #(
		.NUM_POINTS    (NUM_POINTS),
		.MAX_NEIGHBORS (MAX_NEIGHBORS)
	) u_best (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_valid),
		.cfg_data   (cfg_data),
		.cand_valid (cand_valid),
		.cand_dist  (cand_dist),
		.cand_idx   (cand_idx),
		.out_free   (status.out_free),
		.emit_last  (status.emit_last),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.out_rank   (out_rank),
		.out_index  (out_index),
		.out_dist   (out_dist),
		.out_last   (m_tlast)
	);

endmodule

// File: rtl/knps_ctrl.sv
module knps_ctrl
	import knps_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	input  logic    op,
	input  status_t status,
	output logic    s_tready,
	output cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.write = accept && (op == OP_WRITE);
				cmd.start = accept && (op == OP_QUERY);
				if (cmd.start)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_end)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!status.pipe_busy)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = status.out_free;
				if (status.out_free && status.emit_last)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// File: rtl/knps_dist.sv
module knps_dist
	import knps_pkg::*;
#(
	parameter int NUM_POINTS = NUM_POINTS_DEF,
	localparam int TABLE_DEPTH = (NUM_POINTS < TABLE_MAX) ? NUM_POINTS : TABLE_MAX,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [SLOT_W-1:0]  slot,
	input  logic [COORD_W-1:0] pos_x,
	input  logic [COORD_W-1:0] pos_y,
	input  logic [COORD_W-1:0] pos_z,
	input  logic               live,
	output logic               cand_valid,
	output logic [DIST_W-1:0]  cand_dist,
	output logic [IDX_W-1:0]   cand_idx,
	output logic               scan_end,
	output logic               pipe_busy
);

	function automatic logic [ABS_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b);
		logic [ABS_W-1:0] d;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		return d[ABS_W-1] ? ABS_W'(~d + 1'b1) : d;
	endfunction

	logic [3*COORD_W-1:0] mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] alive_q;
	logic [IDX_W-1:0]       addr_q;
	logic                   wr_en;
	logic [COORD_W-1:0]     qx_q, qy_q, qz_q;

	logic [3*COORD_W-1:0] pt_s1;
	logic                 alive_s1, v_s1;
	logic [IDX_W-1:0]     idx_s1;

	logic [ABS_W-1:0] ax_s2, ay_s2, az_s2;
	logic             v_s2;
	logic [IDX_W-1:0] idx_s2;

	logic [SQ_W-1:0]  sx_s3, sy_s3, sz_s3;
	logic             v_s3;
	logic [IDX_W-1:0] idx_s3;

	logic [DIST_W-1:0] dist_s4;
	logic              v_s4;
	logic [IDX_W-1:0]  idx_s4;

	assign wr_en = cmd.write && (32'(slot) < NUM_POINTS);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[slot[IDX_W-1:0]] <= {pos_z, pos_y, pos_x};
		pt_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '0;
			addr_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
		end else begin
			if (wr_en)
				alive_q[slot[IDX_W-1:0]] <= live;
			if (cmd.start)
				addr_q <= '0;
			else if (cmd.scan)
				addr_q <= addr_q + 1'b1;
			v_s1 <= cmd.scan;
			v_s2 <= v_s1 && alive_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qx_q <= pos_x;
			qy_q <= pos_y;
			qz_q <= pos_z;
		end
		alive_s1 <= alive_q[addr_q];
		idx_s1   <= addr_q;

		ax_s2  <= abs_diff(pt_s1[COORD_W-1:0], qx_q);
		ay_s2  <= abs_diff(pt_s1[2*COORD_W-1:COORD_W], qy_q);
		az_s2  <= abs_diff(pt_s1[3*COORD_W-1:2*COORD_W], qz_q);
		idx_s2 <= idx_s1;

		sx_s3  <= SQ_W'(ax_s2 * ax_s2);
		sy_s3  <= SQ_W'(ay_s2 * ay_s2);
		sz_s3  <= SQ_W'(az_s2 * az_s2);
		idx_s3 <= idx_s2;

		dist_s4 <= DIST_W'(sx_s3) + DIST_W'(sy_s3) + DIST_W'(sz_s3);
		idx_s4  <= idx_s3;
	end

	assign scan_end   = (addr_q == IDX_W'(TABLE_DEPTH - 1));
	assign pipe_busy  = v_s1 || v_s2 || v_s3 || v_s4;
	assign cand_valid = v_s4;
	assign cand_dist  = dist_s4;
	assign cand_idx   = idx_s4;

endmodule

// File: rtl/knps_best.sv
module knps_best
	import knps_pkg::*;
#(
	parameter int NUM_POINTS    = NUM_POINTS_DEF,
	parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
	localparam int TABLE_DEPTH = (NUM_POINTS < TABLE_MAX) ? NUM_POINTS : TABLE_MAX,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int K_W   = $clog2(MAX_NEIGHBORS + 1),
	localparam int KI_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 cand_valid,
	input  logic [DIST_W-1:0]    cand_dist,
	input  logic [IDX_W-1:0]     cand_idx,
	output logic                 out_free,
	output logic                 emit_last,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [RANK_W-1:0]    out_rank,
	output logic [IDX_OUT_W-1:0] out_index,
	output logic [DIST_W-1:0]    out_dist,
	output logic                 out_last
);

	logic [CFG_W-1:0]  nw_q;
	logic [K_W-1:0]    k_d, k_q, count_q, rank_q;
	logic [DIST_W-1:0] dist_q [MAX_NEIGHBORS];
	logic [IDX_W-1:0]  idx_q  [MAX_NEIGHBORS];
	logic [MAX_NEIGHBORS-1:0] gt, take;
	logic [KI_W-1:0]   rd;
	logic              hit;

	always_comb begin
		if (nw_q == '0)
			k_d = K_W'(1);
		else if (32'(nw_q) > MAX_NEIGHBORS)
			k_d = K_W'(MAX_NEIGHBORS);
		else
			k_d = K_W'(nw_q);
	end

	// sorted insertion: gt marks entries that move down one place
	always_comb begin
		for (int j = 0; j < MAX_NEIGHBORS; j++) begin
			gt[j]   = (32'(count_q) > j) && (cand_dist < dist_q[j]);
			take[j] = cand_valid && (32'(k_q) > j) && (gt[j] || (32'(count_q) == j));
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_NEIGHBORS; j++) begin
			if (take[j]) begin
				if (j > 0 && gt[(j > 0) ? j - 1 : 0]) begin
					dist_q[j] <= dist_q[(j > 0) ? j - 1 : 0];
					idx_q[j]  <= idx_q[(j > 0) ? j - 1 : 0];
				end else begin
					dist_q[j] <= cand_dist;
					idx_q[j]  <= cand_idx;
				end
			end
		end
	end

	assign rd        = rank_q[KI_W-1:0];
	assign hit       = rank_q < count_q;
	assign out_free  = !m_tvalid || m_tready;
	assign emit_last = (rank_q == k_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nw_q     <= NEIGHBORS_RESET;
			k_q      <= K_W'(1);
			count_q  <= '0;
			rank_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_we)
				nw_q <= cfg_data;
			if (cmd.start) begin
				k_q     <= k_d;
				count_q <= '0;
				rank_q  <= '0;
			end else begin
				if (cand_valid && (count_q < k_q))
					count_q <= count_q + 1'b1;
				if (cmd.emit)
					rank_q <= rank_q + 1'b1;
			end
			if (cmd.emit)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_rank  <= RANK_W'(rank_q);
			out_index <= hit ? IDX_OUT_W'(idx_q[rd]) : NO_INDEX;
			out_dist  <= hit ? dist_q[rd] : '0;
			out_last  <= emit_last;
		end
	end

endmodule

// File: test/k_nearest_point_select_top_tb.sv
module k_nearest_point_select_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import knps_pkg::*;

	localparam int TBL_SIZE = 256;
	localparam int K_MAX    = 16;
	localparam logic signed [COORD_W-1:0] C_MAX = 20'sh7FFFF;
	localparam logic signed [COORD_W-1:0] C_MIN = 20'sh80000;
	localparam int SCRIPT_LEN = 22;
	localparam int NUM_PHASES = 8;
	localparam int PHASE_ITEMS = 52;

	typedef struct packed {
		logic                        op;
		logic [SLOT_W-1:0]           slot;
		logic signed [COORD_W-1:0]   x;
		logic signed [COORD_W-1:0]   y;
		logic signed [COORD_W-1:0]   z;
		logic                        live;
		logic                        pinned;
		logic [IDX_OUT_W-1:0]        pin_idx;
		logic [DIST_W-1:0]           pin_dist;
	} point_cmd_t;

	typedef struct packed {
		logic [RANK_W-1:0]    rank;
		logic [IDX_OUT_W-1:0] idx;
		logic [DIST_W-1:0]    dsq;
		logic                 last;
	} neighbor_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [71:0]      s_tdata;   // slot, pos_x, pos_y, pos_z, live, zero pad
	logic             s_tuser;   // op
	logic             m_tvalid;
	logic             m_tready;
	logic [55:0]      m_tdata;   // rank, point_index, dist_sq, zero pad
	logic             m_tlast;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	k_nearest_point_select_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// table shadow and register shadow
	logic signed [COORD_W-1:0] tbl_x [TBL_SIZE];
	logic signed [COORD_W-1:0] tbl_y [TBL_SIZE];
	logic signed [COORD_W-1:0] tbl_z [TBL_SIZE];
	logic                      tbl_alive [TBL_SIZE];
	logic [CFG_W-1:0]          neighbors_wanted;

	neighbor_t  nearest_q[$];
	point_cmd_t script [SCRIPT_LEN];

	int n_mismatch;
	int n_queries;
	int n_writes;
	int n_results;
	int burst_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL k_nearest_point_select_top");
		$finish;
	end

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		n_mismatch++;
	endtask

	// brute-force scan, ties go to the lower slot
	task automatic find_nearest(input point_cmd_t c);
		logic [DIST_W-1:0] best_d [K_MAX];
		int                best_i [K_MAX];
		int                cnt;
		int                k;
		int                pos;
		longint            dx;
		longint            dy;
		longint            dz;
		logic [DIST_W-1:0] d;
		neighbor_t         r;
		cnt = 0;
		k = (neighbors_wanted == 0) ? 1 : int'(neighbors_wanted);
		if (k > K_MAX)
			k = K_MAX;
		for (int i = 0; i < TBL_SIZE; i++) begin
			if (tbl_alive[i]) begin
				dx = longint'(tbl_x[i]) - longint'(c.x);
				dy = longint'(tbl_y[i]) - longint'(c.y);
				dz = longint'(tbl_z[i]) - longint'(c.z);
				d = DIST_W'(dx * dx + dy * dy + dz * dz);
				pos = cnt;
				while (pos > 0 && d < best_d[pos-1])
					pos--;
				if (pos < k) begin
					for (int j = (cnt < k) ? cnt : k - 1; j > pos; j--) begin
						best_d[j] = best_d[j-1];
						best_i[j] = best_i[j-1];
					end
					best_d[pos] = d;
					best_i[pos] = i;
					if (cnt < k)
						cnt++;
				end
			end
		end
		for (int i = 0; i < k; i++) begin
			r.rank = RANK_W'(i);
			r.idx  = (i < cnt) ? IDX_OUT_W'(best_i[i]) : NO_INDEX;
			r.dsq  = (i < cnt) ? best_d[i] : '0;
			r.last = (i == k - 1);
			if (i == 0 && c.pinned) begin
				r.idx  = c.pin_idx;
				r.dsq  = c.pin_dist;
			end
			nearest_q.push_back(r);
		end
	endtask

	task automatic apply_cmd(input point_cmd_t c);
		if (c.op == OP_WRITE) begin
			tbl_x[c.slot]     = c.x;
			tbl_y[c.slot]     = c.y;
			tbl_z[c.slot]     = c.z;
			tbl_alive[c.slot] = c.live;
			n_writes++;
		end else begin
			find_nearest(c);
			n_queries++;
		end
	endtask

	task automatic push_cmd(input point_cmd_t c);
		@(negedge clk);
		if (burst_left == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 10);
		end
		burst_left--;
		s_tvalid = 1'b1;
		s_tuser  = c.op;
		s_tdata  = {3'b000, c.live, c.z, c.y, c.x, c.slot};
		do @(posedge clk); while (!s_tready);
		apply_cmd(c);
	endtask

	task automatic settle;
		@(negedge clk);
		s_tvalid = 1'b0;
		burst_left = 0;
		while (nearest_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_wanted(input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		neighbors_wanted = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic signed [COORD_W-1:0] pick_coord();
		logic signed [COORD_W-1:0] v;
		case ($urandom_range(0, 19))
			17: v = C_MIN;
			18: v = C_MAX;
			19: v = '0;
			default: begin
				if ($urandom_range(0, 1) == 0)
					v = COORD_W'($signed($urandom_range(0, 128)) - 64);
				else
					v = COORD_W'($urandom);
			end
		endcase
		return v;
	endfunction

	function automatic point_cmd_t random_cmd();
		point_cmd_t c;
		c = '0;
		c.op   = ($urandom_range(0, 3) == 0) ? OP_QUERY : OP_WRITE;
		c.slot = ($urandom_range(0, 2) == 0) ? SLOT_W'($urandom_range(0, 255))
			: SLOT_W'($urandom_range(0, 23));
		c.x    = pick_coord();
		c.y    = pick_coord();
		c.z    = pick_coord();
		c.live = ($urandom_range(0, 3) != 0);
		return c;
	endfunction

	// receiver: long ready stretches, random stalls, occasional long stalls
	initial begin
		m_tready = 1'b0;
		forever begin
			case ($urandom_range(0, 3))
				0: begin
					@(negedge clk);
					m_tready = 1'b1;
					repeat ($urandom_range(20, 80)) @(negedge clk);
				end
				1: begin
					@(negedge clk);
					m_tready = 1'b0;
					repeat ($urandom_range(5, 25)) @(negedge clk);
				end
				default: begin
					repeat ($urandom_range(10, 40)) begin
						@(negedge clk);
						m_tready = ($urandom_range(0, 2) != 0);
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		neighbor_t got;
		neighbor_t exp;
		if (arst_n && m_tvalid && m_tready) begin
			got.rank = m_tdata[3:0];
			got.idx  = m_tdata[12:4];
			got.dsq  = m_tdata[54:13];
			got.last = m_tlast;
			n_results++;
			if (nearest_q.size() == 0) begin
				report($sformatf("unexpected result rank %0d idx %0d", got.rank, got.idx));
			end else begin
				exp = nearest_q.pop_front();
				if (got.rank !== exp.rank)
					report($sformatf("rank got %0d exp %0d", got.rank, exp.rank));
				if (got.idx !== exp.idx)
					report($sformatf("rank %0d point_index got %0d exp %0d",
						exp.rank, $signed(got.idx), $signed(exp.idx)));
				if (got.dsq !== exp.dsq)
					report($sformatf("rank %0d dist_sq got %0d exp %0d",
						exp.rank, got.dsq, exp.dsq));
				if (got.last !== exp.last)
					report($sformatf("rank %0d last got %0b exp %0b",
						exp.rank, got.last, exp.last));
			end
		end
	end

	initial begin
		logic [CFG_W-1:0] phase_k [NUM_PHASES];
		phase_k = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd9, 5'd2, 5'd5};
		script = '{
			'{OP_QUERY, 8'd0,   20'sd0, 20'sd0, 20'sd0, 1'b0, 1'b1, NO_INDEX, 42'd0},
			'{OP_WRITE, 8'd0,   C_MAX, C_MAX, C_MAX, 1'b1, 1'b0, 9'd0, 42'd0},
			'{OP_WRITE, 8'd255, C_MIN, C_MIN, C_MIN, 1'b1, 1'b0, 9'd0, 42'd0},
			'{OP_QUERY, 8'd0,   C_MIN, C_MIN, C_MIN, 1'b0, 1'b1, 9'd255, 42'd0},
			'{OP_QUERY, 8'd0,   C_MAX, C_MAX, C_MAX, 1'b0, 1'b1, 9'd0, 42'd0},
			'{OP_QUERY, 8'd0,   20'sd0, 20'sd0, 20'sd0, 1'b0, 1'b0, 9'd0, 42'd0},
			'{OP_WRITE, 8'd10,  20'sd0, 20'sd0, 20'sd0, 1'b0, 1'b0, 9'd0, 42'd0},
			'{OP_QUERY, 8'd0,   20'sd0, 20'sd0, 20'sd0, 1'b0, 1'b0, 9'd0, 42'd0},
			'{OP_WRITE, 8'd20,  20'sd16, 20'sd0, 20'sd0, 1'b1, 1'b0, 9'd0, 42'd0},
			'{OP_WRITE, 8'd5,   -20'sd16, 20'sd0, 20'sd0, 1'b1, 1'b0, 9'd0, 42'd0},
			'{OP_QUERY, 8'd0,   20'sd0, 20'sd0, 20'sd0, 1'b0, 1'b1, 9'd5, 42'd256},
			'{OP_WRITE, 8'd7,   20'sd0, 20'sd16, 20'sd0, 1'b1, 1'b0, 9'd0, 42'd0},
			'{OP_QUERY, 8'd0,   20'sd0, 20'sd0, 20'sd0, 1'b0, 1'b1, 9'd5, 42'd256},
			'{OP_WRITE, 8'd5,   -20'sd16, 20'sd0, 20'sd0, 1'b0, 1'b0, 9'd0, 42'd0},
			'{OP_QUERY, 8'd0,   20'sd0, 20'sd0, 20'sd0, 1'b0, 1'b1, 9'd7, 42'd256},
			'{OP_WRITE, 8'd30,  20'sd0, 20'sd16, 20'sd0, 1'b1, 1'b0, 9'd0, 42'd0},
			'{OP_QUERY, 8'd0,   20'sd0, 20'sd16, 20'sd0, 1'b0, 1'b1, 9'd7, 42'd0},
			'{OP_WRITE, 8'd10,  20'sd0, 20'sd0, -20'sd16, 1'b1, 1'b0, 9'd0, 42'd0},
			'{OP_QUERY, 8'd0,   20'sd0, 20'sd0, C_MAX, 1'b0, 1'b0, 9'd0, 42'd0},
			'{OP_WRITE, 8'd128, C_MAX, C_MIN, 20'sd1, 1'b1, 1'b0, 9'd0, 42'd0},
			'{OP_QUERY, 8'd0,   C_MIN, C_MAX, 20'sd0, 1'b0, 1'b0, 9'd0, 42'd0},
			'{OP_QUERY, 8'd0,   C_MIN, C_MIN, C_MAX, 1'b0, 1'b0, 9'd0, 42'd0}
		};

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		n_mismatch = 0;
		n_queries  = 0;
		n_writes   = 0;
		n_results  = 0;
		burst_left = 0;
		neighbors_wanted = NEIGHBORS_RESET;
		for (int i = 0; i < TBL_SIZE; i++) begin
			tbl_x[i] = '0;
			tbl_y[i] = '0;
			tbl_z[i] = '0;
			tbl_alive[i] = 1'b0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < SCRIPT_LEN; i++)
			push_cmd(script[i]);
		settle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_wanted(phase_k[p]);
			for (int i = 0; i < PHASE_ITEMS; i++)
				push_cmd(random_cmd());
			settle();
		end

		repeat (40) @(posedge clk);
		$display("covered %0d queries and %0d point writes, %0d results checked",
			n_queries, n_writes, n_results);
		$display("neighbor counts swept over 0, 1, 2, 5, 9, 16, 17, 31 plus reset value");
		if (n_mismatch == 0 && nearest_q.size() == 0)
			$display("PASS k_nearest_point_select_top");
		else
			$display("FAIL k_nearest_point_select_top");
		$finish;
	end

endmodule
